@@ hw/rtl/iqss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I/Q sample statistics package
// Shared types, register indexes and sizing constants for the I/Q sample
// statistics block.
// ----------------------------------------------------------------------------
package iqss_pkg;

   localparam int unsigned ACC_WIDTH_DEFAULT = 48;
   localparam int unsigned QUEUE_DEPTH       = 2;
   localparam int unsigned CSR_INDEX_WIDTH   = 1;
   localparam int unsigned CSR_DATA_WIDTH    = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_FORMAT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLIP_LEVEL   = 1'b1;

   localparam logic FMT_SIGNED16   = 1'b0;
   localparam logic FMT_OFFSET8    = 1'b1;

   localparam logic FUNC_ACCUMULATE = 1'b0;
   localparam logic FUNC_CLEAR      = 1'b1;

   localparam logic [15:0] CLIP_LEVEL_RESET = 16'd32736;
   localparam logic [8:0]  OFFSET8_BIAS     = 9'd127;

   typedef struct packed {
      logic        func;
      logic [15:0] raw_i;
      logic [15:0] raw_q;
   } req_type;

   typedef struct packed {
      logic [47:0]        sample_total;
      logic signed [47:0] sum_in_phase;
      logic signed [47:0] sum_quadrature;
      logic [62:0]        sum_energy;
      logic [15:0]        peak_in_phase;
      logic [15:0]        peak_quadrature;
      logic [47:0]        clip_count_in_phase;
      logic [47:0]        clip_count_quadrature;
   } rsp_type;

   typedef struct packed {
      logic               func;
      logic signed [16:0] val_i;
      logic signed [16:0] val_q;
      logic [15:0]        mag_i;
      logic [15:0]        mag_q;
      logic               clip_i;
      logic               clip_q;
      logic [31:0]        power;
   } entry_type;

endpackage
`default_nettype wire

@@ hw/rtl/iq_sample_statistics.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I/Q sample statistics
// Running level statistics over a stream of raw I/Q samples.
// ----------------------------------------------------------------------------
// The block takes one sample beat per clock while not stalled and returns one
// result beat per sample, in order, with the sample count, the I and Q sums,
// the summed power in Q33.30, the peak magnitudes and the clip counts as they
// stand after that sample. A result reaches the result register by way of the
// front-end register that holds the normalized values and squares and then the
// queue slot ahead of the accumulators. The accumulator update sets the rate
// of one beat per clock when the result side is not stalled; a two-entry queue
// between the front end and the accumulator absorbs a stall on either side.
// ----------------------------------------------------------------------------
module iq_sample_statistics #(
   parameter int unsigned ACC_WIDTH = iqss_pkg::ACC_WIDTH_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    csr_we,
   input  wire [iqss_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [iqss_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  wire                                    req_valid,
   output logic                                   req_stall,
   input  iqss_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  wire                                    rsp_stall,
   output iqss_pkg::rsp_type                      rsp_data
);

   logic                input_format_ff;
   logic [15:0]         clip_level_ff;
   logic                push_valid, push_stall, pop_valid, pop_stall;
   iqss_pkg::entry_type push_entry, pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_format_ff <= iqss_pkg::FMT_SIGNED16;
         clip_level_ff   <= iqss_pkg::CLIP_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            iqss_pkg::CSR_INPUT_FORMAT: input_format_ff <= csr_wdata[0];
            iqss_pkg::CSR_CLIP_LEVEL:   clip_level_ff   <= csr_wdata[15:0];
            default:                    clip_level_ff   <= clip_level_ff;
         endcase
      end
   end

   iqss_front u_front (
      .clock        (clock),
      .reset        (reset),
      .input_format (input_format_ff),
      .clip_level   (clip_level_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .push_valid   (push_valid),
      .push_stall   (push_stall),
      .push_entry   (push_entry)
   );

   iqss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_entry  (pop_entry)
   );

   iqss_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_stall (pop_stall),
      .pop_entry (pop_entry),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ hw/rtl/iqss_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I/Q sample statistics front end
// Accepts sample beats, normalizes both components to Q1.15, forms the
// magnitudes, clip flags and squares, and hands decoded entries to the queue.
// ----------------------------------------------------------------------------
module iqss_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  input_format,
   input  wire [15:0]           clip_level,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  iqss_pkg::req_type    req_data,
   output logic                 push_valid,
   input  wire                  push_stall,
   output iqss_pkg::entry_type  push_entry
);

   logic               stage_valid_ff, stage_valid_in;
   logic               func_ff;
   logic signed [16:0] val_i_ff, val_q_ff, val_i_in, val_q_in;
   logic [15:0]        mag_i_ff, mag_q_ff, mag_i_in, mag_q_in;
   logic               clip_i_ff, clip_q_ff;
   logic [30:0]        sq_i_ff, sq_q_ff;
   logic               take, push;

   function automatic logic signed [16:0] normalize(input logic fmt, input logic [15:0] raw);
      logic [8:0] diff;
      diff = {1'b0, raw[7:0]} - iqss_pkg::OFFSET8_BIAS;
      if (fmt == iqss_pkg::FMT_OFFSET8) begin
         return {diff, 8'h00};
      end
      return {raw[15], raw};
   endfunction

   function automatic logic [15:0] magnitude(input logic signed [16:0] v);
      logic [16:0] m;
      m = v[16] ? 17'(-v) : 17'(v);
      return m[15:0];
   endfunction

   assign push      = stage_valid_ff && !push_stall;
   assign req_stall = stage_valid_ff && push_stall;
   assign take      = req_valid && !req_stall;

   assign val_i_in = normalize(input_format, req_data.raw_i);
   assign val_q_in = normalize(input_format, req_data.raw_q);
   assign mag_i_in = magnitude(val_i_in);
   assign mag_q_in = magnitude(val_q_in);

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (take) begin
         stage_valid_in = 1'b1;
      end else if (push) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         func_ff   <= req_data.func;
         val_i_ff  <= val_i_in;
         val_q_ff  <= val_q_in;
         mag_i_ff  <= mag_i_in;
         mag_q_ff  <= mag_q_in;
         clip_i_ff <= (mag_i_in >= clip_level);
         clip_q_ff <= (mag_q_in >= clip_level);
         sq_i_ff   <= 31'(mag_i_in * mag_i_in);
         sq_q_ff   <= 31'(mag_q_in * mag_q_in);
      end
   end

   assign push_valid        = stage_valid_ff;
   assign push_entry.func   = func_ff;
   assign push_entry.val_i  = val_i_ff;
   assign push_entry.val_q  = val_q_ff;
   assign push_entry.mag_i  = mag_i_ff;
   assign push_entry.mag_q  = mag_q_ff;
   assign push_entry.clip_i = clip_i_ff;
   assign push_entry.clip_q = clip_q_ff;
   assign push_entry.power  = {1'b0, sq_i_ff} + {1'b0, sq_q_ff};

endmodule
`default_nettype wire

@@ hw/rtl/iqss_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I/Q sample statistics queue
// Short first-word-fall-through queue of decoded entries between the front
// end and the accumulator.
// ----------------------------------------------------------------------------
module iqss_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_stall,
   input  iqss_pkg::entry_type  push_entry,
   output logic                 pop_valid,
   input  wire                  pop_stall,
   output iqss_pkg::entry_type  pop_entry
);

   localparam int unsigned PTR_WIDTH = $clog2(iqss_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_WIDTH = $clog2(iqss_pkg::QUEUE_DEPTH + 1);

   iqss_pkg::entry_type  slot_ff [iqss_pkg::QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 push, pop;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p);
      if (p == PTR_WIDTH'(iqss_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign push_stall = (count_ff == CNT_WIDTH'(iqss_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;
   assign pop_entry  = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/iqss_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I/Q sample statistics accumulator
// Holds the running statistics, applies one decoded entry per cycle while the
// result side is not stalled, with saturation, and registers the result beat.
// ----------------------------------------------------------------------------
module iqss_back #(
   parameter int unsigned ACC_WIDTH = iqss_pkg::ACC_WIDTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  pop_valid,
   output logic                 pop_stall,
   input  iqss_pkg::entry_type  pop_entry,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output iqss_pkg::rsp_type    rsp_data
);

   logic                        pop;
   logic                        rsp_valid_ff, rsp_valid_in;
   iqss_pkg::rsp_type           rsp_data_ff, rsp_data_in;
   logic [ACC_WIDTH-1:0]        count_ff, count_in;
   logic signed [ACC_WIDTH-1:0] acc_i_ff, acc_i_in, acc_q_ff, acc_q_in;
   logic [62:0]                 energy_ff, energy_in;
   logic [15:0]                 peak_i_ff, peak_i_in, peak_q_ff, peak_q_in;
   logic [ACC_WIDTH-1:0]        clips_i_ff, clips_i_in, clips_q_ff, clips_q_in;
   logic [63:0]                 energy_sum;

   function automatic logic [ACC_WIDTH-1:0] sat_inc(input logic [ACC_WIDTH-1:0] x);
      if (&x) begin
         return x;
      end
      return x + 1'b1;
   endfunction

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0] acc,
      input logic signed [16:0]          v
   );
      logic signed [ACC_WIDTH:0] sum;
      sum = {acc[ACC_WIDTH-1], acc} + (ACC_WIDTH + 1)'(v);
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
         return sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                               : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      return sum[ACC_WIDTH-1:0];
   endfunction

   assign pop       = pop_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop_stall = rsp_valid_ff && rsp_stall;

   assign energy_sum = {1'b0, energy_ff} + 64'(pop_entry.power);

   always_comb begin
      count_in   = count_ff;
      acc_i_in   = acc_i_ff;
      acc_q_in   = acc_q_ff;
      energy_in  = energy_ff;
      peak_i_in  = peak_i_ff;
      peak_q_in  = peak_q_ff;
      clips_i_in = clips_i_ff;
      clips_q_in = clips_q_ff;
      if (pop) begin
         unique case (pop_entry.func)
            iqss_pkg::FUNC_CLEAR: begin
               count_in   = '0;
               acc_i_in   = '0;
               acc_q_in   = '0;
               energy_in  = '0;
               peak_i_in  = '0;
               peak_q_in  = '0;
               clips_i_in = '0;
               clips_q_in = '0;
            end
            iqss_pkg::FUNC_ACCUMULATE: begin
               count_in  = sat_inc(count_ff);
               acc_i_in  = sat_add(acc_i_ff, pop_entry.val_i);
               acc_q_in  = sat_add(acc_q_ff, pop_entry.val_q);
               energy_in = energy_sum[63] ? '1 : energy_sum[62:0];
               if (pop_entry.mag_i > peak_i_ff) begin
                  peak_i_in = pop_entry.mag_i;
               end
               if (pop_entry.mag_q > peak_q_ff) begin
                  peak_q_in = pop_entry.mag_q;
               end
               if (pop_entry.clip_i) begin
                  clips_i_in = sat_inc(clips_i_ff);
               end
               if (pop_entry.clip_q) begin
                  clips_q_in = sat_inc(clips_q_ff);
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.sample_total          = 48'(64'(count_in));
      rsp_data_in.sum_in_phase          = 48'(64'(acc_i_in));
      rsp_data_in.sum_quadrature        = 48'(64'(acc_q_in));
      rsp_data_in.sum_energy            = energy_in;
      rsp_data_in.peak_in_phase         = peak_i_in;
      rsp_data_in.peak_quadrature       = peak_q_in;
      rsp_data_in.clip_count_in_phase   = 48'(64'(clips_i_in));
      rsp_data_in.clip_count_quadrature = 48'(64'(clips_q_in));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         acc_i_ff     <= '0;
         acc_q_ff     <= '0;
         energy_ff    <= '0;
         peak_i_ff    <= '0;
         peak_q_ff    <= '0;
         clips_i_ff   <= '0;
         clips_q_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         acc_i_ff     <= acc_i_in;
         acc_q_ff     <= acc_q_in;
         energy_ff    <= energy_in;
         peak_i_ff    <= peak_i_in;
         peak_q_ff    <= peak_q_in;
         clips_i_ff   <= clips_i_in;
         clips_q_ff   <= clips_q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A clear beat leaves every statistic at zero in the result it produces.
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      pop && (pop_entry.func == iqss_pkg::FUNC_CLEAR) |=>
         (count_ff == '0) && (energy_ff == '0) && (rsp_data.sample_total == '0))
      else $error("clear beat did not zero the statistics");

   // An accumulated sample always leaves a nonzero count.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      pop && (pop_entry.func == iqss_pkg::FUNC_ACCUMULATE) |=> (count_ff != '0))
      else $error("sample count is zero after an accumulated sample");

   // Peaks never fall except on a clear beat.
   a_peak_monotonic: assert property (@(posedge clock) disable iff (reset)
      !(pop && (pop_entry.func == iqss_pkg::FUNC_CLEAR)) |=>
         (peak_i_ff >= $past(peak_i_ff)) && (peak_q_ff >= $past(peak_q_ff)))
      else $error("peak magnitude decreased without a clear");

   // A held result beat only changes when a new result is loaded.
   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !pop |=> $stable(rsp_data_ff))
      else $error("result register changed without a pop");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// I/Q sample statistics testbench
// Streams raw I/Q sample beats into the block in random bursts and stalls
// the result side on changing patterns. Each accepted sample is run through
// a local model of the running statistics, and every result beat is checked
// field by field against it. The run steps through both input formats and a
// range of clip levels, including zero, full scale and levels above it.
// ----------------------------------------------------------------------------
module tb;
   import iqss_pkg::*;

   localparam int unsigned IDLE_LIMIT    = 2000;
   localparam int unsigned SETTLE_CYCLES = 6;
   localparam int unsigned PHASE_COUNT   = 11;
   localparam int unsigned RANDOM_PER_PHASE = 82;
   localparam logic [47:0] COUNT_MAX  = '1;
   localparam longint      SUM_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint      SUM_MIN    = -SUM_MAX - 1;
   localparam logic [63:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_INPUT_FORMAT;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_data;

   iq_sample_statistics dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   logic        cfg_format = FMT_SIGNED16;
   logic [15:0] cfg_clip   = CLIP_LEVEL_RESET;

   logic [47:0]        stat_count   = '0;
   logic signed [47:0] stat_sum_i   = '0;
   logic signed [47:0] stat_sum_q   = '0;
   logic [63:0]        stat_energy  = '0;
   logic [15:0]        stat_peak_i  = '0;
   logic [15:0]        stat_peak_q  = '0;
   logic [47:0]        stat_clips_i = '0;
   logic [47:0]        stat_clips_q = '0;

   req_type     sample_queue[$];
   rsp_type     expected_stats[$];
   int unsigned samples_accepted = 0;
   int unsigned clears_accepted  = 0;
   int unsigned results_checked  = 0;
   int unsigned mismatches       = 0;
   int unsigned burst_left       = 1;
   int unsigned gap_left         = 0;
   int unsigned stall_mode       = 0;
   int unsigned mode_left        = 0;
   int unsigned idle_cycles      = 0;

   logic        phase_format[PHASE_COUNT];
   logic [15:0] phase_clip[PHASE_COUNT];

   function automatic logic signed [16:0] to_q15(input logic [15:0] code);
      int b;
      b = int'(code[7:0]);
      if (cfg_format == FMT_OFFSET8)
         return 17'((b - 127) * 256);
      return {code[15], code};
   endfunction

   function automatic logic [47:0] bump(input logic [47:0] x);
      return (x == COUNT_MAX) ? x : x + 48'd1;
   endfunction

   function automatic logic signed [47:0] add_clamped(input logic signed [47:0] acc,
                                                      input logic signed [16:0] v);
      longint s;
      s = longint'(acc) + longint'(v);
      if (s > SUM_MAX)
         s = SUM_MAX;
      else if (s < SUM_MIN)
         s = SUM_MIN;
      return 48'(s);
   endfunction

   task automatic update_statistics(input req_type s);
      logic signed [16:0] vi;
      logic signed [16:0] vq;
      logic [15:0]        ai;
      logic [15:0]        aq;
      logic [63:0]        pw;
      rsp_type            r;
      if (s.func == FUNC_CLEAR) begin
         stat_count   = '0;
         stat_sum_i   = '0;
         stat_sum_q   = '0;
         stat_energy  = '0;
         stat_peak_i  = '0;
         stat_peak_q  = '0;
         stat_clips_i = '0;
         stat_clips_q = '0;
      end else begin
         vi = to_q15(s.raw_i);
         vq = to_q15(s.raw_q);
         ai = 16'((vi < 0) ? -vi : vi);
         aq = 16'((vq < 0) ? -vq : vq);
         pw = 64'(ai) * 64'(ai) + 64'(aq) * 64'(aq);
         stat_count  = bump(stat_count);
         stat_sum_i  = add_clamped(stat_sum_i, vi);
         stat_sum_q  = add_clamped(stat_sum_q, vq);
         stat_energy = (stat_energy > ENERGY_MAX - pw) ? ENERGY_MAX : stat_energy + pw;
         if (ai > stat_peak_i)
            stat_peak_i = ai;
         if (aq > stat_peak_q)
            stat_peak_q = aq;
         if (ai >= cfg_clip)
            stat_clips_i = bump(stat_clips_i);
         if (aq >= cfg_clip)
            stat_clips_q = bump(stat_clips_q);
      end
      r.sample_total          = stat_count;
      r.sum_in_phase          = stat_sum_i;
      r.sum_quadrature        = stat_sum_q;
      r.sum_energy            = stat_energy[62:0];
      r.peak_in_phase         = stat_peak_i;
      r.peak_quadrature       = stat_peak_q;
      r.clip_count_in_phase   = stat_clips_i;
      r.clip_count_quadrature = stat_clips_q;
      expected_stats.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("tb: result %0d %s expected %h got %h",
                     results_checked, name, want, got);
      end
   endtask

   function automatic logic [15:0] extreme_code();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h8001;
         3: return 16'hFFFF;
         4: return 16'h0000;
         5: return 16'h0001;
         6: return {8'($urandom), 8'h00};
         default: return {8'($urandom), 8'hFF};
      endcase
   endfunction

   function automatic logic [15:0] near_clip_code();
      int m;
      m = int'(cfg_clip) + int'($urandom_range(0, 4)) - 2;
      if (m < 0)
         m = 0;
      if (m > 32768)
         m = 32768;
      if ($urandom_range(0, 1) == 1)
         m = -m;
      return 16'(m);
   endfunction

   function automatic req_type random_sample();
      req_type     s;
      int unsigned pick;
      s.func  = FUNC_ACCUMULATE;
      s.raw_i = 16'($urandom);
      s.raw_q = 16'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 3) begin
         s.func = FUNC_CLEAR;
      end else if (pick < 30) begin
         s.raw_i = extreme_code();
         s.raw_q = extreme_code();
      end else if (pick < 50 && cfg_format == FMT_SIGNED16) begin
         s.raw_i = near_clip_code();
         s.raw_q = near_clip_code();
      end
      return s;
   endfunction

   task automatic push_sample(input logic func, input logic [15:0] raw_i,
                              input logic [15:0] raw_q);
      req_type s;
      s.func  = func;
      s.raw_i = raw_i;
      s.raw_q = raw_q;
      sample_queue.push_back(s);
   endtask

   task automatic add_directed(input int unsigned phase);
      case (phase)
         0: begin
            push_sample(FUNC_ACCUMULATE, 16'h7FFF, 16'h8000);
            push_sample(FUNC_ACCUMULATE, 16'h8000, 16'h7FFF);
            push_sample(FUNC_ACCUMULATE, 16'hFFFF, 16'h0001);
            push_sample(FUNC_ACCUMULATE, 16'h0000, 16'h0000);
            push_sample(FUNC_ACCUMULATE, 16'h8001, 16'h7FE0);
            push_sample(FUNC_ACCUMULATE, 16'h7FDF, 16'h8020);
            push_sample(FUNC_CLEAR, 16'hA5A5, 16'h5A5A);
            push_sample(FUNC_ACCUMULATE, 16'h1234, 16'hFEDC);
            push_sample(FUNC_CLEAR, 16'hFFFF, 16'hFFFF);
            push_sample(FUNC_CLEAR, 16'h0000, 16'h0000);
         end
         1: begin
            push_sample(FUNC_ACCUMULATE, 16'h00FF, 16'hAB00);
            push_sample(FUNC_ACCUMULATE, 16'hFF7F, 16'h1280);
            push_sample(FUNC_ACCUMULATE, 16'h5A01, 16'h00FE);
            push_sample(FUNC_CLEAR, 16'h00FF, 16'h00FF);
         end
         2: push_sample(FUNC_ACCUMULATE, 16'h0000, 16'h0000);
         4: push_sample(FUNC_ACCUMULATE, 16'h8000, 16'h7FFF);
         5: push_sample(FUNC_ACCUMULATE, 16'h8000, 16'h8000);
         default: ;
      endcase
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] reg_index,
                            input logic [15:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (reg_index == CSR_INPUT_FORMAT)
         cfg_format = value[0];
      else
         cfg_clip = value;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_stats.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_statistics(req_data);
            samples_accepted++;
            if (req_data.func == FUNC_CLEAR)
               clears_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || sample_queue.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= sample_queue.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_stats.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: result beat with no sample waiting: %h", rsp_data);
            end else begin
               want = expected_stats.pop_front();
               check_field("sample_total", 64'(want.sample_total),
                           64'(rsp_data.sample_total));
               check_field("sum_in_phase", 64'(want.sum_in_phase),
                           64'(rsp_data.sum_in_phase));
               check_field("sum_quadrature", 64'(want.sum_quadrature),
                           64'(rsp_data.sum_quadrature));
               check_field("sum_energy", 64'(want.sum_energy),
                           64'(rsp_data.sum_energy));
               check_field("peak_in_phase", 64'(want.peak_in_phase),
                           64'(rsp_data.peak_in_phase));
               check_field("peak_quadrature", 64'(want.peak_quadrature),
                           64'(rsp_data.peak_quadrature));
               check_field("clip_count_in_phase", 64'(want.clip_count_in_phase),
                           64'(rsp_data.clip_count_in_phase));
               check_field("clip_count_quadrature", 64'(want.clip_count_quadrature),
                           64'(rsp_data.clip_count_quadrature));
               results_checked++;
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            mode_left  = $urandom_range(16, 160);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 1) == 0);
            3: rsp_stall <= ($urandom_range(0, 4) != 0);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("tb: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      phase_format = '{FMT_SIGNED16, FMT_OFFSET8, FMT_SIGNED16, FMT_OFFSET8, FMT_SIGNED16,
                       FMT_SIGNED16, FMT_OFFSET8, FMT_SIGNED16, FMT_OFFSET8, FMT_SIGNED16,
                       FMT_SIGNED16};
      phase_clip   = '{CLIP_LEVEL_RESET, CLIP_LEVEL_RESET, 16'd0, 16'd0, 16'd32768,
                       16'd32769, 16'd32768, 16'hFFFF, 16'd0, 16'd0, 16'd16384};
      phase_clip[8] = 16'($urandom_range(1, 32767));
      phase_clip[9] = 16'($urandom_range(1, 32767));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
         if (p != 0) begin
            wait_idle();
            write_reg(CSR_INPUT_FORMAT, 16'(phase_format[p]));
            write_reg(CSR_CLIP_LEVEL, phase_clip[p]);
         end
         add_directed(p);
         repeat (RANDOM_PER_PHASE) sample_queue.push_back(random_sample());
      end
      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_stats.size() != 0) begin
         mismatches += expected_stats.size();
         $display("tb: %0d results never arrived", expected_stats.size());
      end
      $display("tb: %0d samples (%0d of them clears) over %0d register settings",
               samples_accepted, clears_accepted, PHASE_COUNT);
      $display("tb: %0d result beats checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/iqss_pkg.sv
hw/rtl/iqss_front.sv
hw/rtl/iqss_queue.sv
hw/rtl/iqss_back.sv
hw/rtl/iq_sample_statistics.sv
verif/tb.sv
